>>> hdl/jse_pkg.sv
// shared types and constants for the json string escaper
package jse_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_UTF8_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_QUOTES = 1'b1;

    localparam logic [20:0] REPL_POINT = 21'h00fffd;

    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_BSLASH = 7'h5c;
    localparam logic [6:0] CH_SLASH  = 7'h2f;
    localparam logic [6:0] CH_U      = 7'h75;
    localparam logic [6:0] CH_B      = 7'h62;
    localparam logic [6:0] CH_F      = 7'h66;
    localparam logic [6:0] CH_N      = 7'h6e;
    localparam logic [6:0] CH_R      = 7'h72;
    localparam logic [6:0] CH_T      = 7'h74;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_A      = 7'h61;
    localparam logic [6:0] CH_BS     = 7'h08;
    localparam logic [6:0] CH_FF     = 7'h0c;
    localparam logic [6:0] CH_LF     = 7'h0a;
    localparam logic [6:0] CH_CR     = 7'h0d;
    localparam logic [6:0] CH_TAB    = 7'h09;

    typedef enum logic [1:0] {
        MAIN_NONE,
        MAIN_ASCII,
        MAIN_HEX
    } main_kind_t;

    // one decoded item: the pieces of text it produces, in output order
    typedef struct packed {
        logic        open_q;
        logic        rep_pre;
        main_kind_t  main_kind;
        logic        main_esc;
        logic [20:0] main_val;
        logic [2:0]  main_digits;
        logic        rep_post;
        logic        close_q;
        logic        last;
    } job_t;

    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_OPEN,
        SEG_PRE,
        SEG_MAIN,
        SEG_POST,
        SEG_CLOSE
    } seg_t;

endpackage

>>> hdl/jse_front.sv
// front end: utf-8 decode state and classification of each input word
module jse_front import jse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       utf8_mode,
    input  logic       add_quotes,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_first_byte,
    input  logic       s_last_byte,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic [20:0] code_accum_reg, code_accum_next;
    logic [1:0]  pending_count_reg, pending_count_next;
    job_t        job;
    logic        accept;
    logic        nonempty;

    function automatic logic [7:0] esc_code(input logic [6:0] c);
        logic [7:0] r;
        case (c)
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_SLASH:  r = {1'b1, CH_SLASH};
            CH_BS:     r = {1'b1, CH_B};
            CH_FF:     r = {1'b1, CH_F};
            CH_LF:     r = {1'b1, CH_N};
            CH_CR:     r = {1'b1, CH_R};
            CH_TAB:    r = {1'b1, CH_T};
            default:   r = {1'b0, c};
        endcase
        return r;
    endfunction

    function automatic job_t set_ascii(input job_t j, input logic [6:0] c);
        job_t       r;
        logic [7:0] e;
        r = j;
        e = esc_code(c);
        r.main_kind = MAIN_ASCII;
        r.main_esc = e[7];
        r.main_val = {14'd0, e[6:0]};
        r.main_digits = 3'd0;
        return r;
    endfunction

    function automatic job_t set_point(input job_t j, input logic [20:0] cp);
        job_t r;
        r = j;
        if (cp < 21'h80) begin
            r = set_ascii(j, cp[6:0]);
        end else begin
            r.main_kind = MAIN_HEX;
            r.main_esc = 1'b0;
            r.main_val = cp;
            if (cp > 21'h0fffff) begin
                r.main_digits = 3'd6;
            end else if (cp > 21'h00ffff) begin
                r.main_digits = 3'd5;
            end else begin
                r.main_digits = 3'd4;
            end
        end
        return r;
    endfunction

    always_comb begin
        code_accum_next = code_accum_reg;
        pending_count_next = pending_count_reg;
        job = '0;
        if (s_first_byte) begin
            code_accum_next = '0;
            pending_count_next = '0;
            job.open_q = add_quotes;
        end
        if (!utf8_mode) begin
            code_accum_next = '0;
            pending_count_next = '0;
            if (!s_in_byte[7]) begin
                job = set_ascii(job, s_in_byte[6:0]);
            end else begin
                job.main_kind = MAIN_HEX;
                job.main_esc = 1'b0;
                job.main_val = {13'd0, s_in_byte};
                job.main_digits = 3'd2;
            end
        end else if (s_in_byte[7:6] == 2'b10) begin
            if (pending_count_next != 2'd0) begin
                code_accum_next = {code_accum_next[14:0], s_in_byte[5:0]};
                pending_count_next = pending_count_next - 2'd1;
                if (pending_count_next == 2'd0) begin
                    job = set_point(job, code_accum_next);
                    code_accum_next = '0;
                end
            end else begin
                job = set_point(job, REPL_POINT);
            end
        end else begin
            if (pending_count_next != 2'd0) begin
                job.rep_pre = 1'b1;
                pending_count_next = '0;
                code_accum_next = '0;
            end
            if (!s_in_byte[7]) begin
                job = set_ascii(job, s_in_byte[6:0]);
            end else if (s_in_byte < 8'he0) begin
                pending_count_next = 2'd1;
                code_accum_next = {16'd0, s_in_byte[4:0]};
            end else if (s_in_byte < 8'hf0) begin
                pending_count_next = 2'd2;
                code_accum_next = {17'd0, s_in_byte[3:0]};
            end else if (s_in_byte < 8'hf8) begin
                pending_count_next = 2'd3;
                code_accum_next = {18'd0, s_in_byte[2:0]};
            end else begin
                job = set_point(job, REPL_POINT);
            end
        end
        if (s_last_byte) begin
            if (pending_count_next != 2'd0) begin
                job.rep_post = 1'b1;
                pending_count_next = '0;
                code_accum_next = '0;
            end
            job.close_q = add_quotes;
            job.last = 1'b1;
        end
    end

    assign s_ready = !q_full;
    assign accept = s_valid && s_ready;
    assign nonempty = job.open_q || job.rep_pre || (job.main_kind != MAIN_NONE) ||
                      job.rep_post || job.close_q;
    assign push = accept && nonempty;
    assign push_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_accum_reg <= '0;
            pending_count_reg <= '0;
        end else if (accept) begin
            code_accum_reg <= code_accum_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

>>> hdl/jse_queue.sv
// small queue of decoded words between front and back
module jse_queue import jse_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign full = count_reg == (QAW+1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hdl/jse_back.sv
// back end: walks each decoded word and emits one character per cycle while m_ready allows
module jse_back import jse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  job_t       q_head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_out_char,
    output logic       m_last_char
);

    seg_t       seg_reg, seg_next;
    logic [2:0] pos_reg, pos_next;
    job_t       job_reg, job_next;
    logic       m_valid_reg, m_valid_next;
    logic [6:0] m_out_char_reg, m_out_char_next;
    logic       m_last_char_reg, m_last_char_next;

    logic       busy;
    job_t       cur_job;
    seg_t       cur_seg;
    logic [2:0] cur_pos;
    logic       cur_valid;
    logic       adv;
    logic       end_seg;
    seg_t       after;

    function automatic seg_t next_seg(input job_t j, input seg_t s);
        seg_t r;
        if (s < SEG_OPEN && j.open_q) begin
            r = SEG_OPEN;
        end else if (s < SEG_PRE && j.rep_pre) begin
            r = SEG_PRE;
        end else if (s < SEG_MAIN && j.main_kind != MAIN_NONE) begin
            r = SEG_MAIN;
        end else if (s < SEG_POST && j.rep_post) begin
            r = SEG_POST;
        end else if (s < SEG_CLOSE && j.close_q) begin
            r = SEG_CLOSE;
        end else begin
            r = SEG_IDLE;
        end
        return r;
    endfunction

    function automatic logic [3:0] seg_len(input job_t j, input seg_t s);
        logic [3:0] r;
        case (s)
            SEG_PRE, SEG_POST: r = 4'd6;
            SEG_MAIN: begin
                case (j.main_kind)
                    MAIN_ASCII: r = j.main_esc ? 4'd2 : 4'd1;
                    MAIN_HEX:   r = {1'b0, j.main_digits} + 4'd2;
                    default:    r = 4'd1;
                endcase
            end
            default: r = 4'd1;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + {3'd0, v} : CH_A + {3'd0, v} - 7'd10;
    endfunction

    // backslash, u, then the digits from the most significant down
    function automatic logic [6:0] hex_at(input logic [20:0] v, input logic [2:0] d,
                                          input logic [2:0] pos);
        logic [23:0] w;
        logic [2:0]  k;
        logic [6:0]  r;
        w = {3'd0, v};
        k = d + 3'd1 - pos;
        if (pos == 3'd0) begin
            r = CH_BSLASH;
        end else if (pos == 3'd1) begin
            r = CH_U;
        end else begin
            r = hex_char(w[{k, 2'b00} +: 4]);
        end
        return r;
    endfunction

    function automatic logic [6:0] seg_char(input job_t j, input seg_t s,
                                            input logic [2:0] pos);
        logic [6:0] r;
        case (s)
            SEG_PRE, SEG_POST: r = hex_at(REPL_POINT, 3'd4, pos);
            SEG_MAIN: begin
                case (j.main_kind)
                    MAIN_HEX: r = hex_at(j.main_val, j.main_digits, pos);
                    default: begin
                        r = (j.main_esc && pos == 3'd0) ? CH_BSLASH : j.main_val[6:0];
                    end
                endcase
            end
            default: r = CH_QUOTE;
        endcase
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= SEG_IDLE;
            pos_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            seg_reg <= seg_next;
            pos_reg <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        m_out_char_reg <= m_out_char_next;
        m_last_char_reg <= m_last_char_next;
    end

    always_comb begin
        busy = seg_reg != SEG_IDLE;
        cur_job = busy ? job_reg : q_head;
        cur_seg = busy ? seg_reg : next_seg(q_head, SEG_IDLE);
        cur_pos = busy ? pos_reg : 3'd0;
        cur_valid = busy || !q_empty;
        adv = cur_valid && (!m_valid_reg || m_ready);
        q_pop = adv && !busy;
        end_seg = {1'b0, cur_pos} == seg_len(cur_job, cur_seg) - 4'd1;
        after = end_seg ? next_seg(cur_job, cur_seg) : cur_seg;

        seg_next = seg_reg;
        pos_next = pos_reg;
        job_next = job_reg;
        m_valid_next = m_valid_reg;
        m_out_char_next = m_out_char_reg;
        m_last_char_next = m_last_char_reg;

        if (q_pop) begin
            job_next = q_head;
        end
        if (adv) begin
            seg_next = after;
            pos_next = end_seg ? 3'd0 : cur_pos + 3'd1;
            m_valid_next = 1'b1;
            m_out_char_next = seg_char(cur_job, cur_seg, cur_pos);
            m_last_char_next = cur_job.last && (after == SEG_IDLE);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_char = m_out_char_reg;
    assign m_last_char = m_last_char_reg;

endmodule

>>> hdl/json_string_escaper.sv
// json string escaper top level: config registers, front, queue, back
// an accepted word is registered into the queue; the back end then registers its first character onto m_valid
// throughput: one output character per cycle from the back end while m_ready allows; a word
// occupies it until all its characters are sent, words producing nothing never enter the queue
// a four-entry queue between front and back lets input run ahead of escape bursts
// reset clears decode state and the queue, utf8_mode to 0 and add_quotes to 1
module json_string_escaper import jse_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_in_byte,
    input  logic                 s_first_byte,
    input  logic                 s_last_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_out_char,
    output logic                 m_last_char
);

    logic utf8_mode_reg;
    logic add_quotes_reg;
    logic q_full, q_empty, q_push, q_pop;
    job_t q_in, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utf8_mode_reg <= 1'b0;
            add_quotes_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_UTF8_MODE:  utf8_mode_reg <= cfg_data;
                CFG_ADD_QUOTES: add_quotes_reg <= cfg_data;
                default:        utf8_mode_reg <= utf8_mode_reg;
            endcase
        end
    end

    jse_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .utf8_mode    (utf8_mode_reg),
        .add_quotes   (add_quotes_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .q_full       (q_full),
        .push         (q_push),
        .push_job     (q_in)
    );

    jse_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    jse_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

endmodule

>>> dv/json_string_escaper_tb.sv
// self-checking testbench for the json string escaper: random and directed byte strings
module tb;
    import jse_pkg::*;

    localparam int LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic       last;
        logic [6:0] ch;
    } text_char_t;

    class escaped_text_check;
        bit         decode_utf8 = 1'b0;
        bit         quote_strings = 1'b1;
        bit [20:0]  point_bits;
        bit [1:0]   cont_left;
        text_char_t awaited_chars[$];
        bit [6:0]   burst[$];
        int         errors;

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit val);
            if (idx == CFG_UTF8_MODE) decode_utf8 = val;
            else if (idx == CFG_ADD_QUOTES) quote_strings = val;
        endfunction

        function void add_char(bit [6:0] c);
            if (burst.size() < 16) burst.push_back(c);
        endfunction

        function void add_ascii(bit [6:0] c);
            bit [6:0] esc;
            case (c)
                CH_QUOTE:  esc = CH_QUOTE;
                CH_BSLASH: esc = CH_BSLASH;
                CH_SLASH:  esc = CH_SLASH;
                CH_BS:     esc = CH_B;
                CH_FF:     esc = CH_F;
                CH_LF:     esc = CH_N;
                CH_CR:     esc = CH_R;
                CH_TAB:    esc = CH_T;
                default:   esc = 7'd0;
            endcase
            if (esc != 7'd0) begin
                add_char(CH_BSLASH);
                add_char(esc);
            end else begin
                add_char(c);
            end
        endfunction

        function void add_hex(bit [20:0] v, int digits);
            bit [3:0] nib;
            add_char(CH_BSLASH);
            add_char(CH_U);
            for (int i = digits - 1; i >= 0; i--) begin
                nib = v[4*i +: 4];
                add_char(nib < 4'd10 ? CH_ZERO + 7'(nib) : CH_A + 7'(nib - 4'd10));
            end
        endfunction

        function void add_point(bit [20:0] cp);
            if (cp < 21'h80) add_ascii(cp[6:0]);
            else add_hex(cp, cp > 21'hfffff ? 6 : (cp > 21'hffff ? 5 : 4));
        endfunction

        function void note_byte(bit [7:0] b, bit first, bit last);
            burst.delete();
            if (first) begin
                point_bits = '0;
                cont_left = '0;
                if (quote_strings) add_char(CH_QUOTE);
            end
            if (!decode_utf8) begin
                point_bits = '0;
                cont_left = '0;
                if (b < 8'h80) add_ascii(b[6:0]);
                else add_hex({13'd0, b}, 2);
            end else if (b[7:6] == 2'b10) begin
                if (cont_left != 0) begin
                    point_bits = {point_bits[14:0], b[5:0]};
                    cont_left--;
                    if (cont_left == 0) begin
                        add_point(point_bits);
                        point_bits = '0;
                    end
                end else begin
                    add_point(REPL_POINT);
                end
            end else begin
                if (cont_left != 0) begin
                    add_point(REPL_POINT);
                    cont_left = '0;
                    point_bits = '0;
                end
                if (b < 8'h80) begin
                    add_ascii(b[6:0]);
                end else if (b < 8'he0) begin
                    cont_left = 2'd1;
                    point_bits = {16'd0, b[4:0]};
                end else if (b < 8'hf0) begin
                    cont_left = 2'd2;
                    point_bits = {17'd0, b[3:0]};
                end else if (b < 8'hf8) begin
                    cont_left = 2'd3;
                    point_bits = {18'd0, b[2:0]};
                end else begin
                    add_point(REPL_POINT);
                end
            end
            if (last) begin
                if (cont_left != 0) begin
                    add_point(REPL_POINT);
                    cont_left = '0;
                    point_bits = '0;
                end
                if (quote_strings) add_char(CH_QUOTE);
            end
            foreach (burst[i])
                awaited_chars.push_back({last && (i == burst.size() - 1), burst[i]});
        endfunction

        function void check_char(bit [6:0] c, bit last);
            text_char_t want;
            if (awaited_chars.size() == 0) begin
                $display("%0t: unexpected char expected none actual %h last %b", $time, c, last);
                errors++;
                return;
            end
            want = awaited_chars.pop_front();
            if (want.ch != c) begin
                $display("%0t: out_char expected %h actual %h", $time, want.ch, c);
                errors++;
            end
            if (want.last != last) begin
                $display("%0t: last_char expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_in_byte = '0;
    logic                 s_first_byte = 1'b0;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [6:0]           m_out_char;
    logic                 m_last_char;

    escaped_text_check text_check;
    int cycles = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_reqs = 0;
    int hold_dones = 0;
    int words_sent = 0;
    bit [6:0] specials[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB};

    json_string_escaper uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_last_char  (m_last_char)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) text_check.check_char(m_out_char, m_last_char);
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_dones) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_dones++;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic bit [7:0] ascii_byte();
        if ($urandom_range(99) < 40) return {1'b0, specials[$urandom_range(7)]};
        return 8'($urandom_range(127));
    endfunction

    function automatic bit [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(63));
    endfunction

    task automatic send_word(input bit [7:0] b, input bit first, input bit last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_first_byte <= first;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        text_check.note_byte(b, first, last);
        words_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (text_check.awaited_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_mode(input bit utf8, input bit quotes);
        cfg_we <= 1'b1;
        cfg_index <= CFG_UTF8_MODE;
        cfg_data <= utf8;
        @(posedge aclk);
        cfg_index <= CFG_ADD_QUOTES;
        cfg_data <= quotes;
        @(posedge aclk);
        cfg_we <= 1'b0;
        text_check.set_reg(CFG_UTF8_MODE, utf8);
        text_check.set_reg(CFG_ADD_QUOTES, quotes);
    endtask

    task automatic send_string(input bit utf8);
        bit [7:0] text[$];
        int len;
        bit keep_first;
        bit keep_last;
        len = $urandom_range(1, 8);
        keep_first = $urandom_range(99) >= 8;
        keep_last = $urandom_range(99) >= 8;
        while (text.size() < len) begin
            if (!utf8) begin
                case ($urandom_range(2))
                    0: text.push_back(ascii_byte());
                    1: text.push_back(8'($urandom_range(128, 255)));
                    default: text.push_back(8'($urandom_range(255)));
                endcase
            end else begin
                case ($urandom_range(9))
                    0, 1, 2: text.push_back(ascii_byte());
                    3, 4: begin
                        text.push_back(8'hc0 | 8'($urandom_range(31)));
                        text.push_back(cont_byte());
                    end
                    5: begin
                        text.push_back(8'he0 | 8'($urandom_range(15)));
                        text.push_back(cont_byte());
                        text.push_back(cont_byte());
                    end
                    6: begin
                        text.push_back(8'hf0 | 8'($urandom_range(7)));
                        text.push_back(cont_byte());
                        text.push_back(cont_byte());
                        text.push_back(cont_byte());
                    end
                    7: text.push_back(cont_byte());
                    8: text.push_back(8'($urandom_range(8'hc0, 8'hf7)));
                    default: text.push_back(8'($urandom_range(8'hf8, 8'hff)));
                endcase
            end
        end
        foreach (text[i]) send_word(text[i], keep_first && i == 0, keep_last && i == text.size() - 1);
    endtask

    initial begin
        int start;
        text_check = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // raw bytes at the extremes, reset configuration
        send_word(8'h00, 1, 0);
        send_word(8'h7f, 0, 0);
        send_word(8'h80, 0, 0);
        send_word(8'hff, 0, 1);
        wait_idle();
        set_mode(1, 1);

        // overlong slash, euro sign, top of range, stray, interrupted, bad lead, cut short
        send_word(8'hc0, 1, 0);
        send_word(8'haf, 0, 0);
        send_word(8'he2, 0, 0);
        send_word(8'h82, 0, 0);
        send_word(8'hac, 0, 0);
        send_word(8'hf4, 0, 0);
        send_word(8'h8f, 0, 0);
        send_word(8'hbf, 0, 0);
        send_word(8'hbf, 0, 0);
        send_word(8'hbf, 0, 0);
        send_word(8'hc3, 0, 0);
        send_word(8'h22, 0, 0);
        send_word(8'hff, 0, 0);
        send_word(8'he2, 0, 0);
        send_word(8'h82, 0, 1);
        // new string while a sequence is pending
        send_word(8'hf0, 1, 0);
        send_word(8'h9f, 0, 0);
        send_word(8'h5c, 1, 1);
        // mode switch in the middle of a sequence
        send_word(8'he2, 1, 0);
        wait_idle();
        set_mode(0, 1);
        send_word(8'h82, 0, 1);

        for (int phase = 0; phase < 16; phase++) begin
            wait_idle();
            set_mode(phase[0], phase[1]);
            case (phase[3:2])
                2'd0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                2'd1: begin
                    tx_idle_pct = 61;
                    rx_stall_pct <= 0;
                end
                2'd2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 61;
                end
                default: begin
                    tx_idle_pct = 27;
                    rx_stall_pct <= 27;
                end
            endcase
            if (phase == 2) hold_reqs <= hold_reqs + 1;
            start = words_sent;
            while (words_sent - start < 21) send_string(phase[0]);
        end

        wait_idle();
        if (text_check.errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
